@@ src/i2cram_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cram_pkg
// Shared types and codes for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

	localparam int unsigned RegW   = 16;
	localparam int unsigned CfgIdxW = 1;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_RSVD  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BUS_BUSY  = 2'd1,
		ST_START_ERR = 2'd2,
		ST_ADDR_NACK = 2'd3
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PHASE_TICKS   = 1'b0,
		REG_HOLDOFF_TICKS = 1'b1
	} cfg_idx_t;

	localparam logic [RegW-1:0] PHASE_TICKS_RST   = 16'd30;
	localparam logic [RegW-1:0] HOLDOFF_TICKS_RST = 16'd5000;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		status_t    status;
		logic [7:0] read_data;
	} res_t;

endpackage

@@ src/i2cram_seq.sv @@
// ----------------------------------------------------------------------------
// i2cram_seq
// Line sequencer: holds the transaction state and config registers, and
// computes the next state and the result for one item in a single pass.
// ----------------------------------------------------------------------------
module i2cram_seq #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2cram_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [i2cram_pkg::RegW-1:0]         cfg_data,
	input  logic                                step,
	input  i2cram_pkg::item_t                   item,
	output i2cram_pkg::res_t                    res
);
	import i2cram_pkg::*;

	localparam int unsigned LW = (COUNT_WIDTH > RegW) ? COUNT_WIDTH : RegW;
	localparam logic [LW-1:0] CMAX = LW'((64'd1 << COUNT_WIDTH) - 64'd1);

	typedef enum logic [3:0] {
		S_IDLE      = 4'd0,
		S_START     = 4'd1,
		S_SEND_DEV  = 4'd2,
		S_SEND_REG  = 4'd3,
		S_SEND_DATA = 4'd4,
		S_RESTART   = 4'd5,
		S_SEND_DEV1 = 4'd6,
		S_READ      = 4'd7,
		S_NOACK     = 4'd8,
		S_STOP      = 4'd9,
		S_HOLDOFF   = 4'd10,
		S_STOP_NACK = 4'd11
	} stage_t;

	logic [RegW-1:0]        phase_ticks_q, holdoff_ticks_q;
	stage_t                 stage_q, n_stage;
	logic [1:0]             ph_q, n_ph;
	logic [3:0]             bc_q, n_bc;
	logic [7:0]             sb_q, n_sb;
	logic [COUNT_WIDTH-1:0] cnt_q, n_cnt;
	logic [7:0]             dev_q, n_dev, reg_q, n_reg, dat_q, n_dat, lr_q, n_lr;
	logic                   rd_q, n_rd, scl_q, n_scl, sda_q, n_sda;
	logic                   fin, do_go;
	status_t                fin_code;

	logic [LW-1:0]          plim_l, hlim_l;
	logic [COUNT_WIDTH-1:0] plim, hlim, pinc, hinc;
	logic                   pfire, hfire, ack_phase;

	// saturate the tick limits to the counter range
	assign plim_l = (LW'(phase_ticks_q) < CMAX) ? LW'(phase_ticks_q) : CMAX;
	assign hlim_l = (LW'(holdoff_ticks_q) < CMAX) ? LW'(holdoff_ticks_q) : CMAX;
	assign plim   = (plim_l == '0) ? COUNT_WIDTH'(1) : plim_l[COUNT_WIDTH-1:0];
	assign hlim   = hlim_l[COUNT_WIDTH-1:0];
	assign pinc   = (cnt_q < plim) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
	assign hinc   = (cnt_q < hlim) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
	assign pfire  = (pinc >= plim);
	assign hfire  = (hinc >= hlim);

	always_comb begin
		n_stage  = stage_q;
		n_ph     = ph_q;
		n_bc     = bc_q;
		n_sb     = sb_q;
		n_cnt    = cnt_q;
		n_dev    = dev_q;
		n_reg    = reg_q;
		n_dat    = dat_q;
		n_rd     = rd_q;
		n_lr     = lr_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		fin      = 1'b0;
		fin_code = ST_OK;
		do_go    = 1'b0;
		ack_phase = 1'b0;

		if (stage_q == S_IDLE) begin
			if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
				n_dev   = item.dev_addr;
				n_reg   = item.reg_addr;
				n_dat   = item.wr_data;
				n_rd    = (item.opcode == OP_READ);
				n_bc    = '0;
				n_stage = S_START;
				n_ph    = 2'd0;
				n_cnt   = '0;
				do_go   = 1'b1;
			end
		end else if (stage_q == S_HOLDOFF) begin
			n_cnt = hinc;
			if (hfire) begin
				n_stage = S_IDLE;
				n_cnt   = '0;
				fin     = 1'b1;
			end
		end else begin
			n_cnt = pinc;
			if (pfire) begin
				// every phase end restarts the count; finish paths clear do_go
				n_cnt = '0;
				do_go = 1'b1;
				unique case (stage_q)
					S_START: begin
						if (ph_q == 2'd0) begin
							if (!item.sda_in) begin
								fin = 1'b1;
								fin_code = ST_BUS_BUSY;
							end else n_ph = 2'd1;
						end else if (ph_q == 2'd1) begin
							if (item.sda_in) begin
								fin = 1'b1;
								fin_code = ST_START_ERR;
							end else n_ph = 2'd2;
						end else begin
							n_stage = S_SEND_DEV;
							n_ph    = 2'd0;
							n_sb    = dev_q;
							n_bc    = '0;
						end
					end
					S_RESTART: begin
						// failed line checks just shorten the repeated start
						if (ph_q == 2'd0 && item.sda_in) n_ph = 2'd1;
						else if (ph_q == 2'd1 && !item.sda_in) n_ph = 2'd2;
						else begin
							n_stage = S_SEND_DEV1;
							n_ph    = 2'd0;
							n_sb    = dev_q + 8'd1;
							n_bc    = '0;
						end
					end
					S_SEND_DEV, S_SEND_REG, S_SEND_DATA, S_SEND_DEV1: begin
						if (bc_q < 4'd8) begin
							if (ph_q < 2'd2) n_ph = ph_q + 2'd1;
							else begin
								n_bc = bc_q + 4'd1;
								n_ph = 2'd0;
							end
						end else if (ph_q < 2'd2) n_ph = ph_q + 2'd1;
						else if (ph_q == 2'd2) begin
							n_sb = {7'd0, item.sda_in};
							n_ph = 2'd3;
						end else ack_phase = 1'b1;
					end
					S_READ: begin
						if (ph_q == 2'd0) n_ph = 2'd1;
						else begin
							n_sb = {sb_q[6:0], item.sda_in};
							n_bc = bc_q + 4'd1;
							n_stage = (n_bc >= 4'd8) ? S_NOACK : S_READ;
							n_ph = 2'd0;
						end
					end
					S_NOACK: begin
						if (ph_q < 2'd3) n_ph = ph_q + 2'd1;
						else begin
							n_stage = S_STOP;
							n_ph    = 2'd0;
						end
					end
					S_STOP: begin
						if (ph_q < 2'd3) n_ph = ph_q + 2'd1;
						else if (rd_q) begin
							n_lr = sb_q;
							fin  = 1'b1;
						end else if (holdoff_ticks_q == '0) fin = 1'b1;
						else begin
							n_stage = S_HOLDOFF;
							n_ph    = 2'd0;
						end
					end
					S_STOP_NACK: begin
						if (ph_q < 2'd3) n_ph = ph_q + 2'd1;
						else begin
							fin = 1'b1;
							fin_code = ST_ADDR_NACK;
						end
					end
					default: begin
						n_stage = S_IDLE;
						do_go   = 1'b0;
					end
				endcase

				if (ack_phase) begin
					n_ph = 2'd0;
					unique case (stage_q)
						S_SEND_DEV: begin
							if (sb_q[0]) n_stage = S_STOP_NACK;
							else begin
								n_stage = S_SEND_REG;
								n_sb    = reg_q;
								n_bc    = '0;
							end
						end
						S_SEND_REG: begin
							if (rd_q) n_stage = S_RESTART;
							else begin
								n_stage = S_SEND_DATA;
								n_sb    = dat_q;
								n_bc    = '0;
							end
						end
						S_SEND_DATA: n_stage = S_STOP;
						default: begin
							n_stage = S_READ;
							n_sb    = '0;
							n_bc    = '0;
						end
					endcase
				end

				if (fin) begin
					n_stage = S_IDLE;
					n_ph    = 2'd0;
					do_go   = 1'b0;
					if (fin_code != ST_OK && rd_q) n_lr = '0;
				end
			end
		end

		// line levels for the phase just entered
		if (do_go) begin
			unique case (n_stage)
				S_START, S_RESTART: begin
					if (n_ph == 2'd0) begin
						n_scl = 1'b1;
						n_sda = 1'b1;
					end else n_sda = 1'b0;
				end
				S_SEND_DEV, S_SEND_REG, S_SEND_DATA, S_SEND_DEV1: begin
					if (n_bc < 4'd8) begin
						if (n_ph == 2'd0) n_scl = 1'b0;
						else if (n_ph == 2'd1) begin
							n_sda = n_sb[7];
							n_sb  = {n_sb[6:0], 1'b0};
						end else n_scl = 1'b1;
					end else if (n_ph == 2'd0 || n_ph == 2'd3) n_scl = 1'b0;
					else if (n_ph == 2'd1) n_sda = 1'b1;
					else n_scl = 1'b1;
				end
				S_READ: begin
					if (n_ph == 2'd0) begin
						n_scl = 1'b0;
						n_sda = 1'b1;
					end else n_scl = 1'b1;
				end
				S_NOACK: begin
					if (n_ph == 2'd0 || n_ph == 2'd3) n_scl = 1'b0;
					else if (n_ph == 2'd1) n_sda = 1'b1;
					else n_scl = 1'b1;
				end
				S_STOP, S_STOP_NACK: begin
					if (n_ph == 2'd0) n_scl = 1'b0;
					else if (n_ph == 2'd1) n_sda = 1'b0;
					else if (n_ph == 2'd2) n_scl = 1'b1;
					else n_sda = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q   <= PHASE_TICKS_RST;
			holdoff_ticks_q <= HOLDOFF_TICKS_RST;
			stage_q <= S_IDLE;
			ph_q    <= '0;
			bc_q    <= '0;
			sb_q    <= '0;
			cnt_q   <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			dat_q   <= '0;
			rd_q    <= 1'b0;
			lr_q    <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					REG_PHASE_TICKS:   phase_ticks_q   <= cfg_data;
					REG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (step) begin
				stage_q <= n_stage;
				ph_q    <= n_ph;
				bc_q    <= n_bc;
				sb_q    <= n_sb;
				cnt_q   <= n_cnt;
				dev_q   <= n_dev;
				reg_q   <= n_reg;
				dat_q   <= n_dat;
				rd_q    <= n_rd;
				lr_q    <= n_lr;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
			end
		end
	end

	assign res.scl_level = n_scl;
	assign res.sda_level = n_sda;
	assign res.busy_res  = (n_stage != S_IDLE);
	assign res.done_res  = fin;
	assign res.status    = fin ? fin_code : ST_OK;
	assign res.read_data = n_lr;

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && fin |=> stage_q == S_IDLE)
		else $error("finished item did not return to idle");

	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		step && stage_q == S_IDLE && (item.opcode == OP_WRITE || item.opcode == OP_READ)
		|=> stage_q == S_START && ph_q == 2'd0)
		else $error("command in idle did not start a transaction");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(stage_q) && $stable(ph_q) && $stable(cnt_q))
		else $error("sequencer moved without an item");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= 4'd8)
		else $error("bit count out of range");

endmodule

@@ src/i2c_register_access_master.sv @@
// ----------------------------------------------------------------------------
// i2c_register_access_master
// I2C master for single-register writes and reads, driven by tick items.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per handshake: a tick (opcode 0) or, while idle, a
//   write or read command with device address, register address and data.
//   Each item also carries the sampled SDA level. Every item yields exactly
//   one result on m_*: SCL/SDA drive levels, busy, a done pulse with status,
//   and the last byte read.
//   Path: an accepted item waits in the input register; its result is
//   registered in the result register as the sequencer steps.
//   Throughput: one item per cycle unless m_tready stalls; each step is a
//   single pass through the state update logic between the two registers.
//   Stalls: when m_tready is low the result register holds and s_tready
//   drops once the input register is also full; no item is lost.
//   Reset: lines released high, sequencer idle, phase_ticks 30,
//   holdoff_ticks 5000. Config writes (cfg_we) take effect at once and are
//   meant for idle periods only.
// ----------------------------------------------------------------------------
module i2c_register_access_master #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [i2cram_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [i2cram_pkg::RegW-1:0]     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// dev_addr[7:0], reg_addr[15:8], wr_data[23:16], sda_in[24]
	input  logic [31:0]                     s_tdata,
	// opcode[1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// scl_level[0], sda_level[1], busy_res[2], done_res[3], status[5:4],
	// read_data[13:6]
	output logic [15:0]                     m_tdata
);
	import i2cram_pkg::*;

	logic  valid_s1, valid_s2, step;
	item_t item_s1;
	res_t  res_c, res_s2;

	assign step     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode   <= opcode_t'(s_tuser);
			item_s1.dev_addr <= s_tdata[7:0];
			item_s1.reg_addr <= s_tdata[15:8];
			item_s1.wr_data  <= s_tdata[23:16];
			item_s1.sda_in   <= s_tdata[24];
		end
		if (step) res_s2 <= res_c;
	end

	i2cram_seq #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.item      (item_s1),
		.res       (res_c)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.read_data, res_s2.status, res_s2.done_res,
		res_s2.busy_res, res_s2.sda_level, res_s2.scl_level};

endmodule
